/* rtl/dlfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared types, codes and arithmetic helpers of the dense layer block.
// ----------------------------------------------------------------------------
package dlfb_pkg;

  localparam int IDX_W      = 4;
  localparam int IDX_LIMIT  = 16;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 53;
  localparam int RND_W      = 48;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_OUTPUTS = 16;
  localparam int W_DEPTH    = IDX_LIMIT * IDX_LIMIT;
  localparam int W_AW       = 2 * IDX_W;

  localparam logic [3:0] OP_LOAD_W   = 4'd0;
  localparam logic [3:0] OP_LOAD_B   = 4'd1;
  localparam logic [3:0] OP_FWD      = 4'd2;
  localparam logic [3:0] OP_GRAD     = 4'd3;
  localparam logic [3:0] OP_BWD_IN   = 4'd4;
  localparam logic [3:0] OP_RD_GRAD  = 4'd5;
  localparam logic [3:0] OP_CLR_GRAD = 4'd6;
  localparam logic [3:0] OP_DELTA    = 4'd7;
  localparam logic [3:0] OP_RD_PARAM = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = 4'd1;

  localparam logic [2:0] KIND_FWD    = 3'd0;
  localparam logic [2:0] KIND_IGRAD  = 3'd1;
  localparam logic [2:0] KIND_GREAD  = 3'd2;
  localparam logic [2:0] KIND_PREAD  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  typedef enum logic [3:0] {
    M_STATUS = 4'd0,
    M_FWD    = 4'd1,
    M_BWD    = 4'd2,
    M_WGRAD  = 4'd3,
    M_WDELTA = 4'd4,
    M_BDELTA = 4'd5,
    M_RD_W   = 4'd6,
    M_RD_B   = 4'd7,
    M_RD_DW  = 4'd8,
    M_RD_DB  = 4'd9
  } mode_t;

  typedef struct packed {
    logic             valid;
    mode_t            mode;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             emit;
    logic             last;
    logic             err;
  } cmd_t;

  typedef struct packed {
    logic wr_w;
    logic wr_b;
    logic wr_x;
    logic wr_g;
    logic clr_grad;
    logic take_v;
  } store_t;

  typedef struct packed {
    logic out_busy;
    logic res_done;
  } stat_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -ACC_W'(64'sd2147483648);
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[VAL_W-1:0];
  endfunction

  // Q32.32 product to Q16.16, round half up.
  function automatic logic signed [RND_W-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    qround = t[RND_W-1:0];
  endfunction

endpackage

/* rtl/dlfb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dlfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dlfb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_ctrl
// Item decode, configuration registers and the row/column sequencer.
// ----------------------------------------------------------------------------
module dlfb_ctrl import dlfb_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           opcode,
  input  logic [IDX_W-1:0]     row_index,
  input  logic [IDX_W-1:0]     col_index,
  input  logic                 target_bias,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  stat_t                stat,
  output cmd_t                 cmd,
  output store_t               store
);

  localparam int LIM_I = MAX_INPUTS < IDX_LIMIT ? MAX_INPUTS : IDX_LIMIT;
  localparam int LIM_O = MAX_OUTPUTS < IDX_LIMIT ? MAX_OUTPUTS : IDX_LIMIT;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WAIT  = 4'b0010,
    S_ISSUE = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CFG_W-1:0] inputs_in_use, outputs_in_use;
  logic [IDX_W-1:0] nim1, nom1;
  mode_t            mode, mode_next;
  logic             err, err_next;
  logic [IDX_W-1:0] rr, cc, k, m, kl, ml;
  logic [IDX_W-1:0] kl_next, ml_next;
  logic             accept, rbad, cbad, sel_bad;

  function automatic logic [IDX_W-1:0] clamp_m1(input logic [CFG_W-1:0] r, input int lim);
    logic [CFG_W-1:0] l;
    l = CFG_W'(lim);
    if (r == '0) clamp_m1 = '0;
    else if (r > l) clamp_m1 = IDX_W'(l - 1'b1);
    else clamp_m1 = IDX_W'(r - 1'b1);
  endfunction

  assign nim1     = clamp_m1(inputs_in_use, LIM_I);
  assign nom1     = clamp_m1(outputs_in_use, LIM_O);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rbad     = row_index > nim1;
  assign cbad     = col_index > nom1;
  assign sel_bad  = cbad || (!target_bias && rbad);

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use  <= CFG_W'(16);
      outputs_in_use <= CFG_W'(16);
    end else if (cfg_valid) begin
      if (cfg_index == REG_INPUTS) inputs_in_use <= cfg_data;
      else if (cfg_index == REG_OUTPUTS) outputs_in_use <= cfg_data;
    end
  end

  // decode at accept
  always_comb begin
    mode_next = M_STATUS;
    err_next  = 1'b0;
    kl_next   = '0;
    ml_next   = '0;
    store     = '0;
    case (opcode)
      OP_LOAD_W: begin
        err_next   = rbad || cbad;
        store.wr_w = accept && !err_next;
      end
      OP_LOAD_B: begin
        err_next   = cbad;
        store.wr_b = accept && !cbad;
      end
      OP_FWD: begin
        err_next   = rbad;
        store.wr_x = accept && !rbad;
        if (!rbad && row_index == nim1) begin
          mode_next = M_FWD;
          kl_next   = nom1;
          ml_next   = nim1;
        end
      end
      OP_GRAD: begin
        err_next   = cbad;
        store.wr_g = accept && !cbad;
        if (!cbad && col_index == nom1) begin
          mode_next = M_BWD;
          kl_next   = nim1;
          ml_next   = nom1;
        end
      end
      OP_BWD_IN: begin
        err_next     = rbad;
        store.take_v = accept;
        if (!rbad) begin
          mode_next = M_WGRAD;
          ml_next   = nom1;
        end
      end
      OP_RD_GRAD: begin
        err_next = sel_bad;
        if (!sel_bad) mode_next = target_bias ? M_RD_DB : M_RD_DW;
      end
      OP_CLR_GRAD: begin
        store.clr_grad = accept;
      end
      OP_DELTA: begin
        err_next     = sel_bad;
        store.take_v = accept;
        if (!sel_bad) mode_next = target_bias ? M_BDELTA : M_WDELTA;
      end
      OP_RD_PARAM: begin
        err_next = sel_bad;
        if (!sel_bad) mode_next = target_bias ? M_RD_B : M_RD_W;
      end
      default: err_next = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_WAIT;
      S_WAIT:  if (!stat.out_busy) state_next = S_ISSUE;
      S_ISSUE: if (m == ml) state_next = S_DRAIN;
      S_DRAIN: begin
        if (stat.res_done) state_next = (k == kl) ? S_IDLE : S_WAIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= mode_next;
      err  <= err_next;
      kl   <= kl_next;
      ml   <= ml_next;
      rr   <= row_index;
      cc   <= col_index;
      k    <= '0;
      m    <= '0;
    end else if (state == S_ISSUE) begin
      m <= m + 1'b1;
    end else if (state == S_DRAIN && stat.res_done) begin
      k <= k + 1'b1;
      m <= '0;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.valid = (state == S_ISSUE);
    cmd.mode  = mode;
    cmd.err   = err;
    cmd.first = (m == '0);
    cmd.emit  = (m == ml);
    cmd.last  = (k == kl);
    cmd.i     = rr;
    cmd.j     = cc;
    case (mode)
      M_FWD: begin
        cmd.i   = m;
        cmd.j   = k;
        cmd.idx = k;
      end
      M_BWD: begin
        cmd.i   = k;
        cmd.j   = m;
        cmd.idx = k;
      end
      M_WGRAD: cmd.j = m;
      M_RD_W, M_RD_B, M_RD_DW, M_RD_DB: cmd.idx = cc;
      default: cmd.idx = '0;
    endcase
  end

endmodule

/* rtl/dlfb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_datapath
// Parameter and gradient stores, MAC pipeline and result register.
// ----------------------------------------------------------------------------
module dlfb_datapath import dlfb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] value,
  input  cmd_t                    cmd,
  input  store_t                  store,
  output stat_t                   stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] result_value,
  output logic [IDX_W-1:0]        result_index,
  output logic [2:0]              result_kind,
  output logic                    error,
  output logic                    last
);

  logic signed [VAL_W-1:0] bias_store [IDX_LIMIT];
  logic signed [VAL_W-1:0] x_buf      [IDX_LIMIT];
  logic signed [VAL_W-1:0] g_buf      [IDX_LIMIT];
  logic signed [VAL_W-1:0] db_acc     [IDX_LIMIT];
  logic [W_DEPTH-1:0]      dw_valid;
  logic signed [VAL_W-1:0] v_reg;

  logic              w_we, dw_we;
  logic [W_AW-1:0]   w_waddr, dw_waddr, raddr;
  logic [VAL_W-1:0]  w_wdata, dw_wdata, w_q, dw_q;

  cmd_t                    c1, c2;
  logic                    dwv1;
  logic signed [VAL_W-1:0] opa, opb, base1, base2;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc, acc_sum, upd;
  logic signed [RND_W-1:0] rnd;
  logic signed [VAL_W-1:0] res;
  logic [2:0]              kind;
  logic                    emit2;

  assign raddr = {cmd.i, cmd.j};

  dlfb_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(raddr), .rdata(w_q)
  );

  dlfb_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_dw_ram (
    .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
    .raddr(raddr), .rdata(dw_q)
  );

  // small stores and gradient bias accumulators
  always_ff @(posedge clk) begin
    if (store.wr_b) bias_store[col_index] <= value;
    else if (c2.valid && c2.mode == M_BDELTA) bias_store[c2.j] <= sat32(upd);
    if (store.wr_x) x_buf[row_index] <= value;
    if (store.wr_g) g_buf[col_index] <= value;
    if (store.take_v) v_reg <= value;
  end

  always_ff @(posedge clk) begin
    if (rst || store.clr_grad) begin
      for (int n = 0; n < IDX_LIMIT; n++) db_acc[n] <= '0;
    end else if (store.wr_g) begin
      db_acc[col_index] <= sat32(ACC_W'(db_acc[col_index]) + ACC_W'(value));
    end
  end

  // unwritten gradient entries read as zero
  always_ff @(posedge clk) begin
    if (rst || store.clr_grad) dw_valid <= '0;
    else if (dw_we) dw_valid[dw_waddr] <= 1'b1;
  end

  // stage 1: RAM data back, operand select, multiply
  always_ff @(posedge clk) begin
    if (rst) c1.valid <= 1'b0;
    else c1 <= cmd;
    dwv1 <= dw_valid[raddr];
  end

  always_comb begin
    opa   = x_buf[c1.i];
    opb   = w_q;
    base1 = '0;
    case (c1.mode)
      M_FWD:    base1 = bias_store[c1.j];
      M_BWD:    opa = g_buf[c1.j];
      M_WGRAD: begin
        opa   = v_reg;
        opb   = g_buf[c1.j];
        base1 = dwv1 ? dw_q : '0;
      end
      M_WDELTA, M_RD_W: base1 = w_q;
      M_BDELTA, M_RD_B: base1 = bias_store[c1.j];
      M_RD_DW:  base1 = dwv1 ? dw_q : '0;
      M_RD_DB:  base1 = db_acc[c1.j];
      default:  base1 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) c2.valid <= 1'b0;
    else c2 <= c1;
    prod  <= 64'(opa) * 64'(opb);
    base2 <= base1;
  end

  // stage 2: round, accumulate, write back, emit
  assign rnd     = qround(prod);
  assign acc_sum = (c2.first ? ACC_W'(base2) : acc) + ACC_W'(rnd);

  always_comb begin
    upd = ACC_W'(base2) - ACC_W'(v_reg);
    if (c2.mode == M_WGRAD) upd = ACC_W'(base2) + ACC_W'(rnd);
  end

  always_ff @(posedge clk) begin
    if (c2.valid) acc <= acc_sum;
  end

  always_comb begin
    res  = '0;
    kind = KIND_STATUS;
    case (c2.mode)
      M_FWD: begin
        res  = sat32(acc_sum);
        kind = KIND_FWD;
      end
      M_BWD: begin
        res  = sat32(acc_sum);
        kind = KIND_IGRAD;
      end
      M_RD_DW, M_RD_DB: begin
        res  = base2;
        kind = KIND_GREAD;
      end
      M_RD_W, M_RD_B: begin
        res  = base2;
        kind = KIND_PREAD;
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    w_we     = store.wr_w || (c2.valid && c2.mode == M_WDELTA);
    w_waddr  = store.wr_w ? {row_index, col_index} : {c2.i, c2.j};
    w_wdata  = store.wr_w ? value : sat32(upd);
    dw_we    = c2.valid && c2.mode == M_WGRAD;
    dw_waddr = {c2.i, c2.j};
    dw_wdata = sat32(upd);
  end

  assign emit2         = c2.valid && c2.emit;
  assign stat.res_done = emit2;
  assign stat.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit2) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit2) begin
      result_value <= res;
      result_index <= c2.idx;
      result_kind  <= kind;
      error        <= c2.err;
      last         <= c2.last;
    end
  end

endmodule

/* rtl/dense_layer_forward_backward.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_forward_backward
// Fully connected layer, Q16.16, forward pass, backward pass and gradients.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         s_tvalid / s_tready       s_tdata, s_tuser
//  m_axis    out        m_tvalid / m_tready       m_tdata, m_tuser, m_tlast
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item at a time. A column result (forward output or input gradient)
// is accumulated over the row in the MAC pipeline, one MAC per cycle on the
// weight RAM read port; a full row runs its columns one after another.
// Each column waits for the output register to be free. Reset is synchronous
// and clears the gradients at once.
// ----------------------------------------------------------------------------
module dense_layer_forward_backward import dlfb_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // row_index, col_index, value
  input  logic [4:0]           s_tuser,   // opcode, target_bias
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // result_value, result_index, zero pad
  output logic [3:0]           m_tuser,   // result_kind, error
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t                    cmd;
  store_t                  store;
  stat_t                   stat;
  logic signed [VAL_W-1:0] result_value;
  logic [IDX_W-1:0]        result_index;
  logic [2:0]              result_kind;
  logic                    error;

  assign cfg_ready = 1'b1;

  dlfb_ctrl #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .opcode(s_tuser[3:0]), .row_index(s_tdata[3:0]), .col_index(s_tdata[7:4]),
    .target_bias(s_tuser[4]),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .cmd(cmd), .store(store)
  );

  dlfb_datapath u_dp (
    .clk(clk), .rst(rst),
    .row_index(s_tdata[3:0]), .col_index(s_tdata[7:4]), .value(s_tdata[39:8]),
    .cmd(cmd), .store(store), .stat(stat),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .result_value(result_value), .result_index(result_index),
    .result_kind(result_kind), .error(error), .last(m_tlast)
  );

  assign m_tdata = {4'b0000, result_index, result_value};
  assign m_tuser = {error, result_kind};

endmodule
